>>> design/rcft_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcft_pkg - open-file table package
// Field widths, status codes, table entry layout and the microcode ROM.
// ----------------------------------------------------------------------------
package rcft_pkg;

	localparam int SLOT_W = 6;
	localparam int INO_W  = 32;
	localparam int DEV_W  = 4;
	localparam int CNT_W  = 16;

	localparam logic [CNT_W-1:0] REF_MAX = '1;

	typedef enum logic [0:0] {
		FN_OPEN  = 1'b0,
		FN_CLOSE = 1'b1
	} func_t;

	typedef enum logic [1:0] {
		ST_OK         = 2'd0,
		ST_FULL       = 2'd1,
		ST_FREE_CLOSE = 2'd2
	} status_t;

	typedef struct packed {
		logic [CNT_W-1:0] cnt;
		logic [DEV_W-1:0] dev;
		logic [INO_W-1:0] ino;
	} entry_t;

	// program steps
	typedef enum logic [3:0] {
		S_CLR,
		S_IDLE,
		S_ORD,
		S_OCHK,
		S_OHIT,
		S_OEND,
		S_CRD,
		S_CCHK,
		S_PUT
	} ustep_t;

	// datapath operations
	typedef enum logic [3:0] {
		OP_CLEAR,
		OP_WAIT_IN,
		OP_READ_SCAN,
		OP_CHECK_OPEN,
		OP_OPEN_HIT,
		OP_OPEN_END,
		OP_READ_CLOSE,
		OP_CHECK_CLOSE,
		OP_PUT
	} uop_t;

	// jump conditions
	typedef enum logic [2:0] {
		C_NONE,
		C_LAST,
		C_ACC_CLOSE,
		C_ACC,
		C_HIT,
		C_BAD_IDX,
		C_OUT_FREE
	} ucond_t;

	// c1 takes priority over c2; otherwise go to tn
	typedef struct packed {
		uop_t   op;
		ucond_t c1;
		ustep_t t1;
		ucond_t c2;
		ustep_t t2;
		ustep_t tn;
	} uword_t;

	typedef struct packed {
		logic last;
		logic acc_close;
		logic acc;
		logic hit;
		logic bad_idx;
		logic out_free;
	} flags_t;

	function automatic uword_t ucode_rom(ustep_t s);
		uword_t w;
		unique case (s)
			S_CLR:   w = '{OP_CLEAR,       C_LAST,      S_IDLE, C_NONE, S_CLR,  S_CLR};
			S_IDLE:  w = '{OP_WAIT_IN,     C_ACC_CLOSE, S_CRD,  C_ACC,  S_ORD,  S_IDLE};
			S_ORD:   w = '{OP_READ_SCAN,   C_NONE,      S_ORD,  C_NONE, S_ORD,  S_OCHK};
			S_OCHK:  w = '{OP_CHECK_OPEN,  C_HIT,       S_OHIT, C_LAST, S_OEND, S_ORD};
			S_OHIT:  w = '{OP_OPEN_HIT,    C_NONE,      S_PUT,  C_NONE, S_PUT,  S_PUT};
			S_OEND:  w = '{OP_OPEN_END,    C_NONE,      S_PUT,  C_NONE, S_PUT,  S_PUT};
			S_CRD:   w = '{OP_READ_CLOSE,  C_BAD_IDX,   S_PUT,  C_NONE, S_CCHK, S_CCHK};
			S_CCHK:  w = '{OP_CHECK_CLOSE, C_NONE,      S_PUT,  C_NONE, S_PUT,  S_PUT};
			S_PUT:   w = '{OP_PUT,         C_OUT_FREE,  S_IDLE, C_NONE, S_PUT,  S_PUT};
			default: w = '{OP_WAIT_IN,     C_NONE,      S_IDLE, C_NONE, S_IDLE, S_IDLE};
		endcase
		return w;
	endfunction

endpackage

>>> design/rcft_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcft_if - request and response channels
// Valid/ready channels carrying table requests and their results.
// ----------------------------------------------------------------------------
interface rcft_req_if;
	logic                           valid;
	logic                           ready;
	logic                           func;
	logic [rcft_pkg::INO_W-1:0]     inode_number;
	logic [rcft_pkg::DEV_W-1:0]     device_number;
	logic [rcft_pkg::SLOT_W-1:0]    slot_index;

	modport source (output valid, func, inode_number, device_number, slot_index,
		input ready);
	modport sink (input valid, func, inode_number, device_number, slot_index,
		output ready);
endinterface

interface rcft_rsp_if;
	logic                           valid;
	logic                           ready;
	logic [rcft_pkg::SLOT_W-1:0]    result_slot;
	logic [rcft_pkg::CNT_W-1:0]     ref_count;
	logic [1:0]                     status;

	modport source (output valid, result_slot, ref_count, status, input ready);
	modport sink (input valid, result_slot, ref_count, status, output ready);
endinterface

>>> design/rcft_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcft_ram - generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module rcft_ram #(
	parameter int WIDTH = 52,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

>>> design/rcft_seq.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcft_seq - microcode sequencer
// Step counter over the microcode ROM with two prioritized conditional jumps.
// ----------------------------------------------------------------------------
module rcft_seq (
	input  logic             clk,
	input  logic             arst_n,
	input  rcft_pkg::flags_t flags,
	output rcft_pkg::uop_t   op
);

	rcft_pkg::ustep_t pc_q;
	rcft_pkg::uword_t word;

	function automatic logic cond_true(rcft_pkg::ucond_t c, rcft_pkg::flags_t f);
		logic r;
		unique case (c)
			rcft_pkg::C_NONE:      r = 1'b0;
			rcft_pkg::C_LAST:      r = f.last;
			rcft_pkg::C_ACC_CLOSE: r = f.acc_close;
			rcft_pkg::C_ACC:       r = f.acc;
			rcft_pkg::C_HIT:       r = f.hit;
			rcft_pkg::C_BAD_IDX:   r = f.bad_idx;
			rcft_pkg::C_OUT_FREE:  r = f.out_free;
			default:               r = 1'b0;
		endcase
		return r;
	endfunction

	assign word = rcft_pkg::ucode_rom(pc_q);
	assign op   = word.op;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= rcft_pkg::S_CLR;
		end else if (cond_true(word.c1, flags)) begin
			pc_q <= word.t1;
		end else if (cond_true(word.c2, flags)) begin
			pc_q <= word.t2;
		end else begin
			pc_q <= word.tn;
		end
	end

endmodule

>>> design/refcounted_open_file_table_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// refcounted_open_file_table_top - reference-counted open-file table
// Slots keyed by inode and device with 16-bit saturating reference counts.
// ----------------------------------------------------------------------------
// req carries one transaction per operation: open by inode/device, or close
// by slot index. rsp returns exactly one transaction per request with the
// slot, its count after the operation and a status code.
// After reset a clearing pass writes every slot count to zero, one slot a
// cycle; req.ready stays low until it is done.
// Steps, from request accept to result loaded in the output register:
//   open:  a read and a check step per slot of the scan, set by the single
//          RAM read port and its registered read data; then the update step
//   close: a read step, then a check step unless the index is past the table
// One request is processed at a time. The result sits in an output register,
// so the next request is taken while rsp is stalled; the sequencer only waits
// when a new result is ready and the previous one has not been taken.
// ----------------------------------------------------------------------------
module refcounted_open_file_table_top #(
	parameter int SLOTS = 64
) (
	input  logic       clk,
	input  logic       arst_n,
	rcft_req_if.sink   req,
	rcft_rsp_if.source rsp
);

	localparam int AW = $clog2(SLOTS);
	localparam int EW = $bits(rcft_pkg::entry_t);

	rcft_pkg::uop_t   op;
	rcft_pkg::flags_t flags;
	rcft_pkg::entry_t rd;
	rcft_pkg::entry_t ram_wdata;
	logic [EW-1:0]    ram_rdata;
	logic             ram_we;
	logic             ram_re;
	logic [AW-1:0]    ram_waddr;
	logic [AW-1:0]    ram_raddr;

	logic [AW-1:0]                   addr_q;
	logic                            func_q;
	logic [rcft_pkg::INO_W-1:0]      ino_q;
	logic [rcft_pkg::DEV_W-1:0]      dev_q;
	logic [rcft_pkg::SLOT_W-1:0]     idx_q;
	logic                            free_found_q;
	logic [AW-1:0]                   free_slot_q;
	logic [rcft_pkg::SLOT_W-1:0]     res_slot_q;
	logic [rcft_pkg::CNT_W-1:0]      res_cnt_q;
	rcft_pkg::status_t               res_status_q;
	logic                            out_valid_q;
	logic [rcft_pkg::SLOT_W-1:0]     out_slot_q;
	logic [rcft_pkg::CNT_W-1:0]      out_cnt_q;
	rcft_pkg::status_t               out_status_q;

	logic                            accept;
	logic [AW-1:0]                   idx_a;
	logic [rcft_pkg::CNT_W-1:0]      cnt_inc;
	logic [rcft_pkg::CNT_W-1:0]      cnt_dec;

	rcft_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.flags  (flags),
		.op     (op)
	);

	rcft_ram #(
		.WIDTH (EW),
		.DEPTH (SLOTS)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	assign rd        = rcft_pkg::entry_t'(ram_rdata);
	assign req.ready = (op == rcft_pkg::OP_WAIT_IN);
	assign accept    = req.valid && req.ready;
	assign idx_a     = AW'(idx_q);
	assign cnt_inc   = (rd.cnt == rcft_pkg::REF_MAX) ? rd.cnt : rd.cnt + 1'b1;
	assign cnt_dec   = rd.cnt - 1'b1;

	assign flags.last      = (addr_q == AW'(SLOTS - 1));
	assign flags.acc       = accept;
	assign flags.acc_close = accept && (req.func == rcft_pkg::FN_CLOSE);
	assign flags.hit       = (rd.cnt != '0) && (rd.ino == ino_q) && (rd.dev == dev_q);
	assign flags.bad_idx   = (32'(idx_q) >= 32'(SLOTS));
	assign flags.out_free  = !out_valid_q || rsp.ready;

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = addr_q;
		ram_wdata = '0;
		ram_re    = 1'b0;
		ram_raddr = addr_q;
		unique case (op)
			rcft_pkg::OP_CLEAR: begin
				ram_we = 1'b1;
			end
			rcft_pkg::OP_READ_SCAN: begin
				ram_re = 1'b1;
			end
			rcft_pkg::OP_OPEN_HIT: begin
				ram_we    = 1'b1;
				ram_wdata = '{cnt: cnt_inc, dev: dev_q, ino: ino_q};
			end
			rcft_pkg::OP_OPEN_END: begin
				ram_we    = free_found_q;
				ram_waddr = free_slot_q;
				ram_wdata = '{cnt: rcft_pkg::CNT_W'(1), dev: dev_q, ino: ino_q};
			end
			rcft_pkg::OP_READ_CLOSE: begin
				ram_re    = 1'b1;
				ram_raddr = idx_a;
			end
			rcft_pkg::OP_CHECK_CLOSE: begin
				ram_we    = (rd.cnt != '0);
				ram_waddr = idx_a;
				ram_wdata = '{cnt: cnt_dec, dev: rd.dev, ino: rd.ino};
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			addr_q       <= '0;
			free_found_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (rsp.valid && rsp.ready && !(op == rcft_pkg::OP_PUT && flags.out_free)) begin
				out_valid_q <= 1'b0;
			end
			unique case (op)
				rcft_pkg::OP_CLEAR: begin
					addr_q <= flags.last ? '0 : addr_q + 1'b1;
				end
				rcft_pkg::OP_WAIT_IN: begin
					if (accept) begin
						func_q       <= req.func;
						ino_q        <= req.inode_number;
						dev_q        <= req.device_number;
						idx_q        <= req.slot_index;
						addr_q       <= '0;
						free_found_q <= 1'b0;
					end
				end
				rcft_pkg::OP_CHECK_OPEN: begin
					if (!flags.hit) begin
						if (rd.cnt == '0 && !free_found_q) begin
							free_found_q <= 1'b1;
							free_slot_q  <= addr_q;
						end
						if (!flags.last) begin
							addr_q <= addr_q + 1'b1;
						end
					end
				end
				rcft_pkg::OP_OPEN_HIT: begin
					res_slot_q   <= rcft_pkg::SLOT_W'(addr_q);
					res_cnt_q    <= cnt_inc;
					res_status_q <= rcft_pkg::ST_OK;
				end
				rcft_pkg::OP_OPEN_END: begin
					if (free_found_q) begin
						res_slot_q   <= rcft_pkg::SLOT_W'(free_slot_q);
						res_cnt_q    <= rcft_pkg::CNT_W'(1);
						res_status_q <= rcft_pkg::ST_OK;
					end else begin
						res_slot_q   <= '0;
						res_cnt_q    <= '0;
						res_status_q <= rcft_pkg::ST_FULL;
					end
				end
				rcft_pkg::OP_READ_CLOSE: begin
					res_slot_q   <= idx_q;
					res_cnt_q    <= '0;
					res_status_q <= rcft_pkg::ST_FREE_CLOSE;
				end
				rcft_pkg::OP_CHECK_CLOSE: begin
					res_slot_q <= idx_q;
					if (rd.cnt == '0) begin
						res_cnt_q    <= '0;
						res_status_q <= rcft_pkg::ST_FREE_CLOSE;
					end else begin
						res_cnt_q    <= cnt_dec;
						res_status_q <= rcft_pkg::ST_OK;
					end
				end
				rcft_pkg::OP_PUT: begin
					if (flags.out_free) begin
						out_valid_q  <= 1'b1;
						out_slot_q   <= res_slot_q;
						out_cnt_q    <= res_cnt_q;
						out_status_q <= res_status_q;
					end
				end
				default: begin
				end
			endcase
		end
	end

	assign rsp.valid       = out_valid_q;
	assign rsp.result_slot = out_slot_q;
	assign rsp.ref_count   = out_cnt_q;
	assign rsp.status      = out_status_q;

	// a close never reaches the open scan
	a_close_no_scan: assert property (@(posedge clk) disable iff (!arst_n)
		(op == rcft_pkg::OP_READ_SCAN) |-> (func_q == rcft_pkg::FN_OPEN))
		else $error("open scan running for a close transaction");

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		(req.valid && req.ready) |=> !req.ready)
		else $error("request accepted twice in a row");

	a_put_before_valid: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp.valid) |-> $past(op == rcft_pkg::OP_PUT))
		else $error("response raised outside the put step");

	a_full_fields: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && rsp.status == rcft_pkg::ST_FULL) |->
		(rsp.ref_count == '0 && rsp.result_slot == '0))
		else $error("table full response with nonzero fields");

	a_ok_nonzero_open: assert property (@(posedge clk) disable iff (!arst_n)
		(op == rcft_pkg::OP_OPEN_HIT) |=> (res_cnt_q != '0))
		else $error("open hit produced a zero count");

endmodule

>>> test/rcft_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcft_checker - open-file table scoreboard
// Keeps its own copy of the slot table, updates it on every accepted request
// and compares each result transaction with the oldest predicted one.
// ----------------------------------------------------------------------------
module rcft_checker #(
	parameter int SLOTS = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	rcft_req_if         req,
	rcft_rsp_if         rsp,
	output int unsigned fail_count,
	output int unsigned pending,
	output int unsigned results_seen,
	output int unsigned full_opens,
	output int unsigned max_count_opens,
	output int unsigned free_closes
);

	typedef struct packed {
		logic [rcft_pkg::SLOT_W-1:0] slot;
		logic [rcft_pkg::CNT_W-1:0]  cnt;
		rcft_pkg::status_t           status;
	} slot_result_t;

	logic [rcft_pkg::CNT_W-1:0] slot_cnt [SLOTS];
	logic [rcft_pkg::INO_W-1:0] slot_ino [SLOTS];
	logic [rcft_pkg::DEV_W-1:0] slot_dev [SLOTS];
	slot_result_t               expected_results [$];

	function automatic slot_result_t predict_table_op(rcft_pkg::func_t op,
		logic [rcft_pkg::INO_W-1:0] ino, logic [rcft_pkg::DEV_W-1:0] dev,
		logic [rcft_pkg::SLOT_W-1:0] idx);
		slot_result_t r;
		int found;
		r = '{slot: '0, cnt: '0, status: rcft_pkg::ST_FULL};
		found = -1;
		if (op == rcft_pkg::FN_OPEN) begin
			for (int s = 0; s < SLOTS; s++)
				if (found < 0 && slot_cnt[s] != '0 && slot_ino[s] == ino && slot_dev[s] == dev)
					found = s;
			if (found >= 0) begin
				if (slot_cnt[found] == rcft_pkg::REF_MAX)
					max_count_opens++;
				else
					slot_cnt[found] = slot_cnt[found] + 1'b1;
				r = '{slot: rcft_pkg::SLOT_W'(found), cnt: slot_cnt[found],
					status: rcft_pkg::ST_OK};
			end else begin
				for (int s = 0; s < SLOTS; s++)
					if (found < 0 && slot_cnt[s] == '0)
						found = s;
				if (found >= 0) begin
					slot_ino[found] = ino;
					slot_dev[found] = dev;
					slot_cnt[found] = rcft_pkg::CNT_W'(1);
					r = '{slot: rcft_pkg::SLOT_W'(found), cnt: slot_cnt[found],
						status: rcft_pkg::ST_OK};
				end else begin
					full_opens++;
				end
			end
		end else if (int'(idx) >= SLOTS || slot_cnt[idx] == '0) begin
			r = '{slot: idx, cnt: '0, status: rcft_pkg::ST_FREE_CLOSE};
			free_closes++;
		end else begin
			slot_cnt[idx] = slot_cnt[idx] - 1'b1;
			r = '{slot: idx, cnt: slot_cnt[idx], status: rcft_pkg::ST_OK};
		end
		return r;
	endfunction

	task automatic check_field(input string name, input logic [31:0] expv,
		input logic [31:0] actv);
		if (actv !== expv) begin
			fail_count++;
			$error("%s: expected %0d, actual %0d", name, expv, actv);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		slot_result_t exp_r;
		if (!arst_n) begin
			for (int s = 0; s < SLOTS; s++)
				slot_cnt[s] = '0;
			expected_results.delete();
			fail_count      = 0;
			results_seen    = 0;
			full_opens      = 0;
			max_count_opens = 0;
			free_closes     = 0;
			pending         = 0;
		end else begin
			if (rsp.valid === 1'b1 && rsp.ready === 1'b1) begin
				results_seen++;
				if (expected_results.size() == 0) begin
					fail_count++;
					$error("result transaction with none expected: slot %0d count %0d status %0d",
						rsp.result_slot, rsp.ref_count, rsp.status);
				end else begin
					exp_r = expected_results.pop_front();
					check_field("result_slot", 32'(exp_r.slot), 32'(rsp.result_slot));
					check_field("ref_count", 32'(exp_r.cnt), 32'(rsp.ref_count));
					check_field("status", 32'(exp_r.status), 32'(rsp.status));
				end
			end
			if (req.valid === 1'b1 && req.ready === 1'b1)
				expected_results.push_back(predict_table_op(rcft_pkg::func_t'(req.func),
					req.inode_number, req.device_number, req.slot_index));
			pending = expected_results.size();
		end
	end

endmodule

>>> test/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb - open-file table testbench
// Drives open and close requests: free-slot closes, repeated opens of one
// key, a table filled past full, then random traffic under three
// backpressure profiles. Checking is done by rcft_checker.
// ----------------------------------------------------------------------------
module tb;

	localparam int SLOTS          = 64;
	localparam int RAND_PER_PHASE = 280;
	localparam int HOT_OPENS      = 20;
	localparam logic [rcft_pkg::INO_W-1:0] HOT_INO = 32'h1357_9BDF;
	localparam logic [rcft_pkg::DEV_W-1:0] HOT_DEV = 4'h9;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	int          send_idle_pct = 19;
	int          recv_idle_pct = 80;
	int unsigned requests_sent = 0;

	int unsigned fail_count;
	int unsigned pending;
	int unsigned results_seen;
	int unsigned full_opens;
	int unsigned max_count_opens;
	int unsigned free_closes;

	rcft_req_if req();
	rcft_rsp_if rsp();

	always #4 clk = ~clk;

	refcounted_open_file_table_top #(.SLOTS(SLOTS)) u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp)
	);

	rcft_checker #(.SLOTS(SLOTS)) u_chk (
		.clk             (clk),
		.arst_n          (arst_n),
		.req             (req),
		.rsp             (rsp),
		.fail_count      (fail_count),
		.pending         (pending),
		.results_seen    (results_seen),
		.full_opens      (full_opens),
		.max_count_opens (max_count_opens),
		.free_closes     (free_closes)
	);

	always @(negedge clk) begin
		rsp.ready = arst_n ? ($urandom_range(99) >= recv_idle_pct) : 1'b0;
	end

	task automatic send_request(input rcft_pkg::func_t f,
		input logic [rcft_pkg::INO_W-1:0] ino, input logic [rcft_pkg::DEV_W-1:0] dev,
		input logic [rcft_pkg::SLOT_W-1:0] idx);
		while ($urandom_range(99) < send_idle_pct) begin
			req.valid = 1'b0;
			@(negedge clk);
		end
		req.valid         = 1'b1;
		req.func          = f;
		req.inode_number  = ino;
		req.device_number = dev;
		req.slot_index    = idx;
		@(posedge clk);
		while (req.ready !== 1'b1)
			@(posedge clk);
		requests_sent++;
		@(negedge clk);
	endtask

	task automatic drain_results();
		req.valid = 1'b0;
		while (pending != 0)
			@(negedge clk);
	endtask

	initial begin
		logic [rcft_pkg::INO_W-1:0] ino_pool [8];
		logic [rcft_pkg::INO_W-1:0] ino;
		logic [rcft_pkg::DEV_W-1:0] dev;
		int                         open_pct;

		ino_pool = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0001, 32'h8000_0000,
			32'h5555_5555, 32'hAAAA_AAAA, 32'h0000_1000, 32'h7FFF_FFFF};
		open_pct = 50;

		req.valid         = 1'b0;
		req.func          = rcft_pkg::FN_OPEN;
		req.inode_number  = '0;
		req.device_number = '0;
		req.slot_index    = '0;
		repeat (10) @(negedge clk);
		arst_n = 1'b1;

		// closes on an empty table
		send_request(rcft_pkg::FN_CLOSE, '0, '0, rcft_pkg::SLOT_W'(0));
		send_request(rcft_pkg::FN_CLOSE, '1, '1, rcft_pkg::SLOT_W'(SLOTS - 1));

		// pile references on slot 0
		for (int n = 0; n < HOT_OPENS; n++)
			send_request(rcft_pkg::FN_OPEN, HOT_INO, HOT_DEV, rcft_pkg::SLOT_W'($urandom));
		send_request(rcft_pkg::FN_CLOSE, '0, '0, rcft_pkg::SLOT_W'(0));
		send_request(rcft_pkg::FN_OPEN, HOT_INO, HOT_DEV, '0);

		// extreme keys, same inode on another device, reuse of the lowest free slot
		send_request(rcft_pkg::FN_OPEN, 32'h0000_0000, 4'h0, '1);
		send_request(rcft_pkg::FN_OPEN, 32'hFFFF_FFFF, 4'hF, '0);
		send_request(rcft_pkg::FN_OPEN, 32'h0000_0000, 4'hF, '1);
		send_request(rcft_pkg::FN_OPEN, 32'hFFFF_FFFF, 4'h0, '0);
		send_request(rcft_pkg::FN_OPEN, 32'h0000_0000, 4'h0, '0);
		send_request(rcft_pkg::FN_CLOSE, '1, '1, rcft_pkg::SLOT_W'(1));
		send_request(rcft_pkg::FN_CLOSE, '0, '0, rcft_pkg::SLOT_W'(1));
		send_request(rcft_pkg::FN_CLOSE, '1, '0, rcft_pkg::SLOT_W'(1));
		send_request(rcft_pkg::FN_OPEN, 32'hFFFF_FFFF, 4'hF, '0);
		send_request(rcft_pkg::FN_OPEN, 32'h8000_0001, 4'hA, '0);
		send_request(rcft_pkg::FN_CLOSE, '0, '1, rcft_pkg::SLOT_W'(SLOTS - 2));

		// fill the table and keep opening
		for (int n = 0; n < SLOTS + 6; n++)
			send_request(rcft_pkg::FN_OPEN, 32'hF000_0000 | rcft_pkg::INO_W'(n),
				rcft_pkg::DEV_W'(n), rcft_pkg::SLOT_W'($urandom));
		send_request(rcft_pkg::FN_OPEN, 32'h0000_0000, 4'hF, '0);
		send_request(rcft_pkg::FN_CLOSE, '0, '0, rcft_pkg::SLOT_W'(3));
		send_request(rcft_pkg::FN_CLOSE, '0, '0, rcft_pkg::SLOT_W'(3));
		send_request(rcft_pkg::FN_OPEN, 32'h00C0_FFEE, 4'h3, '0);
		send_request(rcft_pkg::FN_OPEN, 32'h00C0_FFEF, 4'h3, '0);

		for (int ph = 0; ph < 3; ph++) begin
			drain_results();
			send_idle_pct = (ph == 0) ? 19 : (ph == 1) ? 80 : 0;
			recv_idle_pct = (ph == 0) ? 80 : (ph == 1) ? 19 : 0;
			for (int n = 0; n < RAND_PER_PHASE; n++) begin
				// drift between filling and draining the table
				if (n % 40 == 0)
					open_pct = $urandom_range(20, 90);
				if ($urandom_range(99) < 65) begin
					ino = ino_pool[$urandom_range(7)];
					dev = rcft_pkg::DEV_W'($urandom_range(3)) |
						($urandom_range(1) ? 4'hC : 4'h0);
				end else begin
					ino = rcft_pkg::INO_W'($urandom);
					dev = rcft_pkg::DEV_W'($urandom);
				end
				if ($urandom_range(99) < open_pct)
					send_request(rcft_pkg::FN_OPEN, ino, dev, rcft_pkg::SLOT_W'($urandom));
				else
					send_request(rcft_pkg::FN_CLOSE, ino, dev, rcft_pkg::SLOT_W'($urandom));
			end
		end

		drain_results();
		repeat (2 * SLOTS + 10) @(negedge clk);

		$display("Sent %0d requests, checked %0d results across three backpressure profiles.",
			requests_sent, results_seen);
		$display("Hit %0d opens on a full table, %0d opens at the count limit, %0d free-slot closes.",
			full_opens, max_count_opens, free_closes);
		if (fail_count == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

	initial begin
		#(400_000_000);
		$display("Test completed with failures");
		$finish;
	end

endmodule
